// File: hw/rtl/sv39ptw_pkg.sv
// ----------------------------------------------------------------------------
// Sv39 page table walker package
// Store geometry, entry flag positions, action codes and the store write beat.
// ----------------------------------------------------------------------------
package sv39ptw_pkg;

  localparam int TABLE_PAGES      = 16;
  localparam int ENTRIES_PER_PAGE = 512;
  localparam int STORE_DEPTH      = TABLE_PAGES * ENTRIES_PER_PAGE;
  localparam int PAGE_W           = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
  localparam int ADDR_W           = $clog2(STORE_DEPTH);

  localparam int PTE_W  = 54;
  localparam int PPN_W  = 44;
  localparam int VA_W   = 39;
  localparam int PA_W   = 56;
  localparam int IDX_W  = 9;
  localparam int ROOT_W = 4;

  // Entry flag bit positions
  localparam int FLAG_V_BIT = 0;
  localparam int FLAG_U_BIT = 4;

  // Item action codes
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_XLATE = 1'b1;

  // One write beat into the entry store
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [PTE_W-1:0]  data;
  } store_wr_t;

  // True when a page number names a page inside the store
  function automatic logic page_ok(input logic [PPN_W-1:0] page);
    page_ok = (page < PPN_W'(TABLE_PAGES));
  endfunction

  // Flat store address of one entry of one page
  function automatic logic [ADDR_W-1:0] entry_addr(input logic [PPN_W-1:0] page,
                                                   input logic [IDX_W-1:0] idx);
    entry_addr = ADDR_W'({page[PAGE_W-1:0], idx});
  endfunction

endpackage

// File: hw/rtl/sv39ptw_store.sv
// ----------------------------------------------------------------------------
// Sv39 page table walker entry store
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module sv39ptw_store
  import sv39ptw_pkg::*;
(
  input  logic              clk,
  input  store_wr_t         wr,
  input  logic [ADDR_W-1:0] raddr,
  output logic [PTE_W-1:0]  rdata
);

  logic [PTE_W-1:0] mem [STORE_DEPTH];

  // Write one entry per beat
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Register the read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/sv39_page_table_walker.sv
// ----------------------------------------------------------------------------
// Sv39 page table walker
// Three-level translation over an internal store of page table pages.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat: raise start with action and its fields while busy is low; the
//   beat is taken at that edge. action = write stores entry_value at
//   (table_page, entry_index); action = translate walks virt_addr from the
//   root page held in the configuration register.
//   Configuration: cfg_wr_en with cfg_wr_data writes root_table_page at the
//   edge; write it only while the walker is idle.
//   Result beat: done is high for one cycle with phys_addr and fault. Every
//   item gives exactly one result. The receiver cannot hold results off.
// Timing:
//   A write, or a translate that faults on its range or root check, gives its
//   result in the cycle after acceptance. A walk makes one store read per
//   level through the single read port with registered data; busy stays high
//   through the walk, so no new item is taken while the walk is under way.
// Reset:
//   rst clears the root register and starts a clearing pass that writes zero
//   to all 8192 store entries, one per cycle; busy stays high during it.
// ----------------------------------------------------------------------------
module sv39_page_table_walker
  import sv39ptw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              action,
  input  logic [3:0]        table_page,
  input  logic [IDX_W-1:0]  entry_index,
  input  logic [PTE_W-1:0]  entry_value,
  input  logic [VA_W-1:0]   virt_addr,
  input  logic              cfg_wr_en,
  input  logic [ROOT_W-1:0] cfg_wr_data,
  output logic              done,
  output logic [PA_W-1:0]   phys_addr,
  output logic              fault
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_WALK  = 2'd2;

  logic [1:0]        state, state_next;
  logic [1:0]        lvl, lvl_next;
  logic [ADDR_W-1:0] clr_addr;
  logic [ROOT_W-1:0] root;
  logic [17:0]       vpn_lo, vpn_lo_next;
  logic              done_next, fault_next;
  logic [PA_W-1:0]   phys_next;

  store_wr_t         wr;
  logic [ADDR_W-1:0] raddr;
  logic [PTE_W-1:0]  rdata;
  logic              accept;
  logic [PPN_W-1:0]  pte_ppn;
  logic [IDX_W-1:0]  next_idx;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign pte_ppn = rdata[PTE_W-1:10];
  assign next_idx = (lvl == 2'd2) ? vpn_lo[17:9] : vpn_lo[8:0];

  sv39ptw_store u_store (
    .clk   (clk),
    .wr    (wr),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Select the store write beat: clearing pass or an item write
  always_comb begin
    wr.we   = 1'b0;
    wr.addr = clr_addr;
    wr.data = '0;
    if (state == S_CLEAR) begin
      wr.we = 1'b1;
    end else if (accept && action == ACT_WRITE) begin
      wr.we   = page_ok(PPN_W'(table_page));
      wr.addr = entry_addr(PPN_W'(table_page), entry_index);
      wr.data = entry_value;
    end
  end

  // Sequence the clearing pass, item acceptance and the walk: one store read per level, check each entry as it lands
  always_comb begin
    state_next  = state;
    lvl_next    = lvl;
    vpn_lo_next = vpn_lo;
    done_next   = 1'b0;
    fault_next  = 1'b0;
    phys_next   = '0;
    raddr       = entry_addr(PPN_W'(root), virt_addr[38:30]);
    case (state)
      S_CLEAR: begin
        if (clr_addr == ADDR_W'(STORE_DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (action == ACT_WRITE) begin
            done_next = 1'b1;
          end else if (virt_addr[38] || !page_ok(PPN_W'(root))) begin
            done_next  = 1'b1;
            fault_next = 1'b1;
          end else begin
            state_next  = S_WALK;
            lvl_next    = 2'd2;
            vpn_lo_next = virt_addr[29:12];
          end
        end
      end
      S_WALK: begin
        raddr = entry_addr(pte_ppn, next_idx);
        if (lvl != 2'd0) begin
          if (!rdata[FLAG_V_BIT] || !page_ok(pte_ppn)) begin
            state_next = S_IDLE;
            done_next  = 1'b1;
            fault_next = 1'b1;
          end else begin
            lvl_next = lvl - 2'd1;
          end
        end else begin
          state_next = S_IDLE;
          done_next  = 1'b1;
          if (!rdata[FLAG_V_BIT] || !rdata[FLAG_U_BIT]) begin
            fault_next = 1'b1;
          end else begin
            phys_next = {pte_ppn, 12'b0};
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Advance control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      root     <= '0;
      done     <= 1'b0;
      lvl      <= 2'd0;
    end else begin
      state <= state_next;
      lvl   <= lvl_next;
      done  <= done_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (cfg_wr_en) begin
        root <= cfg_wr_data;
      end
    end
  end

  // Hold payload
  always_ff @(posedge clk) begin
    vpn_lo    <= vpn_lo_next;
    fault     <= fault_next;
    phys_addr <= phys_next;
  end

  // A faulting result carries a zero address
  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    done && fault |-> phys_addr == '0)
    else $error("fault result with nonzero address");

  // An accepted item either finishes next cycle or keeps the walker busy
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    accept |=> done || busy)
    else $error("accepted item lost");

  // The level counter never leaves the three Sv39 levels during a walk
  a_walk_level: assert property (@(posedge clk) disable iff (rst)
    state == S_WALK |-> lvl != 2'd3)
    else $error("walk level out of range");

  // The store is written only by the clearing pass or an accepted write item
  a_store_write: assert property (@(posedge clk) disable iff (rst)
    wr.we |-> state == S_CLEAR || (accept && action == ACT_WRITE))
    else $error("unexpected store write");

endmodule
